### src/tnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tnh_pkg;

   // Sideband that travels with each beat down the pipeline
   typedef struct packed {
      logic valid;   // stage holds a live beat
      logic neg;     // input was negative
      logic sat;     // |x| >= 6, magnitude forced to one
   } tnh_tag_type;

   // 1.0 in Q0.30 and Q1.14
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [15:0] ONE_Q14 = 16'd16384;

   // |x| threshold for saturation, Q4.12 (6.0)
   localparam logic [16:0] SAT_MAG = 17'd24576;

   // Reciprocal divider: bits of 2^60 + s/2 above the 31 quotient bits
   localparam logic [31:0] RECIP_TOP = 32'h2000_0000;

   // Last series term index
   localparam int unsigned SERIES_LAST = 16;

endpackage

`default_nettype wire

### src/tnh_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The caller supplies the upper partial remainder (must be below the
// divisor) and the low dividend bits that still have to be brought down.
module tnh_div
   import tnh_pkg::*;
#(
   parameter int unsigned QuoWidth = 16,
   parameter int unsigned DenWidth = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tnh_tag_type         in_tag,
   input  wire logic [DenWidth-1:0] in_rem,
   input  wire logic [QuoWidth-1:0] in_low,
   input  wire logic [DenWidth-1:0] in_den,
   output tnh_tag_type              out_tag,
   output logic      [QuoWidth-1:0] out_quo
);

   tnh_tag_type         tag_at [QuoWidth+1];
   logic [DenWidth-1:0] rem_at [QuoWidth+1];
   logic [DenWidth-1:0] den_at [QuoWidth+1];
   logic [QuoWidth-1:0] low_at [QuoWidth+1];
   logic [QuoWidth-1:0] quo_at [QuoWidth+1];

   assign tag_at[0] = in_tag;
   assign rem_at[0] = in_rem;
   assign den_at[0] = in_den;
   assign low_at[0] = in_low;
   assign quo_at[0] = '0;

   for (genvar i = 0; i < QuoWidth; i++) begin : g_step
      logic [DenWidth:0]   trial;
      logic [DenWidth:0]   diff;
      logic                take;
      logic [DenWidth-1:0] rem_in;
      logic [QuoWidth-1:0] low_in;
      logic [QuoWidth-1:0] quo_in;
      tnh_tag_type         tag_ff;
      logic [DenWidth-1:0] rem_ff;
      logic [DenWidth-1:0] den_ff;
      logic [QuoWidth-1:0] low_ff;
      logic [QuoWidth-1:0] quo_ff;

      // bring down one bit, subtract if it fits
      always_comb begin
         trial  = {rem_at[i], low_at[i][QuoWidth-1]};
         diff   = trial - {1'b0, den_at[i]};
         take   = (trial >= {1'b0, den_at[i]});
         rem_in = take ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
         low_in = {low_at[i][QuoWidth-2:0], 1'b0};
         quo_in = {quo_at[i][QuoWidth-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff <= '0;
         end else begin
            tag_ff <= tag_at[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         den_ff <= den_at[i];
         low_ff <= low_in;
         quo_ff <= quo_in;
      end

      assign tag_at[i+1] = tag_ff;
      assign rem_at[i+1] = rem_ff;
      assign den_at[i+1] = den_ff;
      assign low_at[i+1] = low_ff;
      assign quo_at[i+1] = quo_ff;
   end

   assign out_tag = tag_at[QuoWidth];
   assign out_quo = quo_at[QuoWidth];

endmodule

`default_nettype wire

### src/elementwise_tanh_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Elementwise tanh, signed Q4.12 in, signed Q1.14 out (saturates at +/-1.0).
//
// Input: drive req_x_value and raise start; the beat is taken at the rising
// edge where start is high and busy is low. busy is high only during reset,
// so a new element can be taken on every clock cycle.
// Output: each result shows on rsp_tanh_value for one cycle with rsp_strobe
// high, in input order. Throughput is one element per cycle.
// The receiver cannot stall and need not: the pipeline never holds.
// The pipeline stages are: 1 input stage, 45 for the exp(v) series
// (15 terms, each multiply / reciprocal multiply / correct), 31 for the
// one-bit-per-stage reciprocal divider, 4 squarings, 1 setup, 16 for the
// final quotient divider and 1 output register.
// Reset clears every stage valid bit; no beats are in flight afterwards.
module elementwise_tanh_core
   import tnh_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_x_value,
   output logic                    rsp_strobe,
   output logic signed [15:0]      rsp_tanh_value
);

   localparam int unsigned NumTerms = SERIES_LAST - 1;   // n = 2..16
   localparam logic [61:0] RoundQ30 = 62'h2000_0000;

   assign busy = reset;

   // ---------------------------------------------------------------
   // Input stage: magnitude, saturation flag, v = a / 32768 in Q0.30
   // ---------------------------------------------------------------
   logic [16:0] mag_abs;
   logic        sat_now;
   logic [14:0] mag_use;
   tnh_tag_type in_tag_in;
   tnh_tag_type in_tag_ff;
   logic [29:0] in_v_ff;

   always_comb begin
      mag_abs = req_x_value[15] ? (17'h1_0000 - {1'b0, req_x_value})
                                : {1'b0, req_x_value};
      sat_now = (mag_abs >= SAT_MAG);
      mag_use = sat_now ? 15'd0 : mag_abs[14:0];
      in_tag_in.valid = start & ~busy;
      in_tag_in.neg   = req_x_value[15];
      in_tag_in.sat   = sat_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff <= '0;
      end else begin
         in_tag_ff <= in_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      in_v_ff <= {mag_use, 15'd0};
   end

   // ---------------------------------------------------------------
   // exp(v) series: first term is v itself, then term = (term*v>>30)/n
   // ---------------------------------------------------------------
   tnh_tag_type ser_tag_at  [NumTerms+1];
   logic [29:0] ser_term_at [NumTerms+1];
   logic [29:0] ser_v_at    [NumTerms+1];
   logic [31:0] ser_s_at    [NumTerms+1];

   assign ser_tag_at[0]  = in_tag_ff;
   assign ser_term_at[0] = in_v_ff;
   assign ser_v_at[0]    = in_v_ff;
   assign ser_s_at[0]    = {1'b0, ONE_Q30} + {2'b00, in_v_ff};

   for (genvar j = 0; j < NumTerms; j++) begin : g_term
      localparam int unsigned Div      = j + 2;
      localparam logic [29:0] RecipMul = 30'((32'd1 << 30) / Div);

      tnh_tag_type a_tag_ff;
      logic [59:0] a_prod_ff;
      logic [29:0] a_v_ff;
      logic [31:0] a_s_ff;

      tnh_tag_type b_tag_ff;
      logic [29:0] b_p_ff;
      logic [59:0] b_pm_ff;
      logic [29:0] b_v_ff;
      logic [31:0] b_s_ff;

      tnh_tag_type c_tag_ff;
      logic [29:0] c_term_ff;
      logic [29:0] c_term_in;
      logic [29:0] c_v_ff;
      logic [31:0] c_s_ff;
      logic [29:0] q_est;
      logic [29:0] rem_est;

      // quotient estimate is exact or one short; fix with one compare
      always_comb begin
         q_est     = b_pm_ff[59:30];
         rem_est   = b_p_ff - 30'(q_est * 5'(Div));
         c_term_in = q_est + ((rem_est >= 30'(Div)) ? 30'd1 : 30'd0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_tag_ff <= '0;
            b_tag_ff <= '0;
            c_tag_ff <= '0;
         end else begin
            a_tag_ff <= ser_tag_at[j];
            b_tag_ff <= a_tag_ff;
            c_tag_ff <= b_tag_ff;
         end
      end

      always_ff @(posedge clock) begin
         // term * v
         a_prod_ff <= 60'(ser_term_at[j]) * 60'(ser_v_at[j]);
         a_v_ff    <= ser_v_at[j];
         a_s_ff    <= ser_s_at[j];
         // divide by n via reciprocal
         b_p_ff    <= a_prod_ff[59:30];
         b_pm_ff   <= 60'(a_prod_ff[59:30]) * 60'(RecipMul);
         b_v_ff    <= a_v_ff;
         b_s_ff    <= a_s_ff;
         // correct and accumulate
         c_term_ff <= c_term_in;
         c_v_ff    <= b_v_ff;
         c_s_ff    <= b_s_ff + {2'b00, c_term_in};
      end

      assign ser_tag_at[j+1]  = c_tag_ff;
      assign ser_term_at[j+1] = c_term_ff;
      assign ser_v_at[j+1]    = c_v_ff;
      assign ser_s_at[j+1]    = c_s_ff;
   end

   // ---------------------------------------------------------------
   // R = (2^60 + s/2) / s, exp(-v) in Q0.30
   // ---------------------------------------------------------------
   tnh_tag_type rcp_tag;
   logic [30:0] rcp_quo;

   tnh_div #(
      .QuoWidth (31),
      .DenWidth (32)
   ) u_rcp_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (ser_tag_at[NumTerms]),
      .in_rem  (RECIP_TOP),
      .in_low  (ser_s_at[NumTerms][31:1]),
      .in_den  (ser_s_at[NumTerms]),
      .out_tag (rcp_tag),
      .out_quo (rcp_quo)
   );

   // ---------------------------------------------------------------
   // E = R^16: four rounded squarings
   // ---------------------------------------------------------------
   tnh_tag_type sq_tag_at [5];
   logic [30:0] sq_r_at   [5];

   assign sq_tag_at[0] = rcp_tag;
   assign sq_r_at[0]   = rcp_quo;

   for (genvar k = 0; k < 4; k++) begin : g_square
      logic [61:0] sq_prod;
      tnh_tag_type sq_tag_ff;
      logic [30:0] sq_r_ff;

      assign sq_prod = 62'(sq_r_at[k]) * 62'(sq_r_at[k]) + RoundQ30;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_tag_ff <= '0;
         end else begin
            sq_tag_ff <= sq_tag_at[k];
         end
      end

      always_ff @(posedge clock) begin
         sq_r_ff <= sq_prod[60:30];
      end

      assign sq_tag_at[k+1] = sq_tag_ff;
      assign sq_r_at[k+1]   = sq_r_ff;
   end

   // ---------------------------------------------------------------
   // Setup: clamp E, num = 1 - E, den = 1 + E
   // ---------------------------------------------------------------
   logic [30:0] e_clamp;
   tnh_tag_type set_tag_ff;
   logic [30:0] set_num_ff;
   logic [31:0] set_den_ff;

   assign e_clamp = (sq_r_at[4] > ONE_Q30) ? ONE_Q30 : sq_r_at[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         set_tag_ff <= '0;
      end else begin
         set_tag_ff <= sq_tag_at[4];
      end
   end

   always_ff @(posedge clock) begin
      set_num_ff <= ONE_Q30 - e_clamp;
      set_den_ff <= {1'b0, ONE_Q30} + {1'b0, e_clamp};
   end

   // ---------------------------------------------------------------
   // q = (num << 15) / den, 16 quotient bits
   // ---------------------------------------------------------------
   tnh_tag_type quo_tag;
   logic [15:0] quo_val;

   tnh_div #(
      .QuoWidth (16),
      .DenWidth (32)
   ) u_quo_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (set_tag_ff),
      .in_rem  ({2'b00, set_num_ff[30:1]}),
      .in_low  ({set_num_ff[0], 15'd0}),
      .in_den  (set_den_ff),
      .out_tag (quo_tag),
      .out_quo (quo_val)
   );

   // ---------------------------------------------------------------
   // Output: round half up, saturate, apply sign
   // ---------------------------------------------------------------
   logic [16:0] mag_round;
   logic [15:0] mag_out;
   logic [15:0] res_in;
   logic        rsp_strobe_ff;
   logic [15:0] rsp_value_ff;

   always_comb begin
      mag_round = {1'b0, quo_val} + 17'd1;
      mag_out   = quo_tag.sat ? ONE_Q14 : mag_round[16:1];
      res_in    = quo_tag.neg ? (~mag_out + 16'd1) : mag_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= quo_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= res_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_tanh_value = rsp_value_ff;

endmodule

`default_nettype wire
